// File: rtl/i2a_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// i2a_pkg
// Types, control store and character tables shared by the integer to
// ascii formatter modules.
// ---------------------------------------------------------------------------
package i2a_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned MAG_W   = 32;
	localparam int unsigned QUOT_W  = 29;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned TOTAL_W = 31;
	localparam int unsigned STEP_W  = 3;

	localparam logic [MAG_W-1:0]   RECIP_TEN  = 32'hCCCC_CCCD;
	localparam int unsigned        RECIP_SHIFT = 35;
	localparam logic [CNT_W-1:0]   DEC_DIGITS = 5'd10;
	localparam logic [CNT_W-1:0]   HEX_DIGITS = 5'd16;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 31'h7FFF_FFFF;
	localparam logic [7:0]         CHAR_MINUS = 8'h2D;

	localparam logic [1:0] MODE_DEC   = 2'd0;
	localparam logic [1:0] MODE_UPPER = 2'd2;

	typedef logic [STEP_W-1:0] step_t;

	// program addresses
	localparam step_t ST_LOAD  = 3'd0;
	localparam step_t ST_MUL   = 3'd1;
	localparam step_t ST_REM   = 3'd2;
	localparam step_t ST_SIGN  = 3'd3;
	localparam step_t ST_MINUS = 3'd4;
	localparam step_t ST_SKIP  = 3'd5;
	localparam step_t ST_EMIT  = 3'd6;
	localparam step_t ST_DONE  = 3'd7;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_REM,
		OP_CNT10,
		OP_MINUS,
		OP_SKIP,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_IN_HEX,
		C_LOOP,
		C_POS,
		C_SKIP
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} ctrl_t;

	typedef struct packed {
		logic in_hex;
		logic neg;
		logic cnt_one;
		logic skip_more;
		logic out_free;
	} status_t;

	// control store: jump to target when cond holds, else next step
	function automatic ctrl_word_t rom_word(input step_t s);
		ctrl_word_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, target: ST_LOAD};
		unique case (s)
			ST_LOAD:  w = '{op: OP_LOAD,  cond: C_IN_HEX, target: ST_SKIP};
			ST_MUL:   w = '{op: OP_MUL,   cond: C_NEVER,  target: ST_LOAD};
			ST_REM:   w = '{op: OP_REM,   cond: C_LOOP,   target: ST_MUL};
			ST_SIGN:  w = '{op: OP_CNT10, cond: C_POS,    target: ST_SKIP};
			ST_MINUS: w = '{op: OP_MINUS, cond: C_NEVER,  target: ST_LOAD};
			ST_SKIP:  w = '{op: OP_SKIP,  cond: C_SKIP,   target: ST_SKIP};
			ST_EMIT:  w = '{op: OP_EMIT,  cond: C_LOOP,   target: ST_EMIT};
			ST_DONE:  w = '{op: OP_NONE,  cond: C_ALWAYS, target: ST_LOAD};
			default:  w = '{op: OP_NONE,  cond: C_ALWAYS, target: ST_LOAD};
		endcase
		return w;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		c = 8'h30;
		unique case (d)
			4'h0: c = 8'h30;
			4'h1: c = 8'h31;
			4'h2: c = 8'h32;
			4'h3: c = 8'h33;
			4'h4: c = 8'h34;
			4'h5: c = 8'h35;
			4'h6: c = 8'h36;
			4'h7: c = 8'h37;
			4'h8: c = 8'h38;
			4'h9: c = 8'h39;
			4'hA: c = upper ? 8'h41 : 8'h61;
			4'hB: c = upper ? 8'h42 : 8'h62;
			4'hC: c = upper ? 8'h43 : 8'h63;
			4'hD: c = upper ? 8'h44 : 8'h64;
			4'hE: c = upper ? 8'h45 : 8'h65;
			4'hF: c = upper ? 8'h46 : 8'h66;
			default: c = 8'h30;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/integer_to_ascii_formatter_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Prints one integer per input beat as ascii text, one character per
// output beat, most significant digit first.
// ---------------------------------------------------------------------------
// Input beat: tuser carries the mode (0 signed decimal of the low 32 bits,
// 1 lower-case hex, 2 upper-case hex, 3 as 1), tdata the 64-bit value.
// Output beat: tdata carries the character and the saturating count of
// characters sent since reset; tlast marks the final character of a number.
// A short microprogram runs each number: load, ten divide-by-ten steps
// of a multiply and a remainder step each in decimal mode, optional minus
// sign, leading zero skip at one nibble per cycle, then one character per
// cycle while the output register is free. Hex runs load, skip or emit
// steps and a return step; decimal adds the divide steps, a count reload
// and the optional minus sign.
// Only one number is in work at a time; s_axis_tready is high only while
// the sequencer waits at its load step. A stalled receiver holds the
// output beat and the sequencer waits on the next character.
// Reset clears the character count and returns the sequencer to load.
// ---------------------------------------------------------------------------
module integer_to_ascii_formatter_top
	import i2a_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [63:0] value
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] mode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // [7:0] char_code, [38:8] chars_written, [39] zero
	output logic             m_axis_tlast   // last_char
);

	ctrl_t              ctrl;
	status_t            stat;
	logic [7:0]         out_char;
	logic [TOTAL_W-1:0] out_total;

	i2a_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_ready (s_axis_tready)
	);

	i2a_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_mode   (s_axis_tuser),
		.in_value  (s_axis_tdata),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_char  (out_char),
		.out_last  (m_axis_tlast),
		.out_total (out_total)
	);

	assign m_axis_tdata = {1'b0, out_total, out_char};

endmodule
`default_nettype wire

// File: rtl/i2a_seq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// i2a_seq
// Step counter and control store; evaluates jump conditions and holds a
// step while its beat cannot move.
// ---------------------------------------------------------------------------
module i2a_seq
	import i2a_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire status_t stat,
	output ctrl_t        ctrl,
	output logic         in_ready
);

	step_t      pc_q;
	ctrl_word_t cw;
	logic       hold;
	logic       taken;

	always_comb begin
		cw = rom_word(pc_q);
	end

	always_comb begin
		hold = ((cw.op == OP_LOAD) && !in_valid) ||
		       (((cw.op == OP_MINUS) || (cw.op == OP_EMIT)) && !stat.out_free);
	end

	always_comb begin
		unique case (cw.cond)
			C_NEVER:  taken = 1'b0;
			C_ALWAYS: taken = 1'b1;
			C_IN_HEX: taken = stat.in_hex;
			C_LOOP:   taken = !stat.cnt_one;
			C_POS:    taken = !stat.neg;
			C_SKIP:   taken = stat.skip_more;
			default:  taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_LOAD;
		end else if (!hold) begin
			pc_q <= taken ? cw.target : pc_q + step_t'(1);
		end
	end

	assign ctrl.op   = cw.op;
	assign ctrl.fire = !hold;
	assign in_ready  = (cw.op == OP_LOAD);

endmodule
`default_nettype wire

// File: rtl/i2a_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// i2a_dp
// Datapath: magnitude and digit registers, divide-by-ten unit, output
// register and running character count.
// ---------------------------------------------------------------------------
module i2a_dp
	import i2a_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctrl_t              ctrl,
	input  wire logic [1:0]         in_mode,
	input  wire logic [VALUE_W-1:0] in_value,
	input  wire logic               out_ready,
	output status_t                 stat,
	output logic                    out_valid,
	output logic [7:0]              out_char,
	output logic                    out_last,
	output logic [TOTAL_W-1:0]      out_total
);

	logic [MAG_W-1:0]   mag_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [VALUE_W-1:0] digs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic               upper_q;
	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               last_q;
	logic [TOTAL_W-1:0] total_q;

	logic                 in_hex;
	logic                 in_neg;
	logic [MAG_W-1:0]     in_low;
	logic [2*MAG_W-1:0]   prod;
	logic [3:0]           q10_lo;
	logic [3:0]           rem;
	logic                 skip_more;
	logic                 emit;
	logic [TOTAL_W-1:0]   total_inc;

	assign in_hex = (in_mode != MODE_DEC);
	assign in_low = in_value[MAG_W-1:0];
	assign in_neg = !in_hex && in_low[MAG_W-1];
	assign prod   = (2*MAG_W)'(mag_q) * (2*MAG_W)'(RECIP_TEN);
	// low nibble of quotient times ten, enough since the remainder is below ten
	assign q10_lo = {quot_q[0], 3'b000} + {quot_q[2:0], 1'b0};
	assign rem    = mag_q[3:0] - q10_lo;
	assign skip_more = (digs_q[VALUE_W-1 -: 4] == 4'h0) && (cnt_q > CNT_W'(1));
	assign emit      = ctrl.fire && ((ctrl.op == OP_MINUS) || (ctrl.op == OP_EMIT));
	assign total_inc = (total_q == TOTAL_MAX) ? total_q : total_q + TOTAL_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			case (ctrl.op)
				OP_LOAD: begin
					mag_q   <= in_neg ? (~in_low + MAG_W'(1)) : in_low;
					digs_q  <= in_hex ? in_value : '0;
					cnt_q   <= in_hex ? HEX_DIGITS : DEC_DIGITS;
					neg_q   <= in_neg;
					upper_q <= (in_mode == MODE_UPPER);
				end
				OP_MUL: begin
					quot_q <= prod[RECIP_SHIFT +: QUOT_W];
				end
				OP_REM: begin
					digs_q <= {rem, digs_q[VALUE_W-1:4]};
					mag_q  <= MAG_W'(quot_q);
					cnt_q  <= cnt_q - CNT_W'(1);
				end
				OP_CNT10: begin
					cnt_q <= DEC_DIGITS;
				end
				OP_SKIP: begin
					if (skip_more) begin
						digs_q <= {digs_q[VALUE_W-5:0], 4'h0};
						cnt_q  <= cnt_q - CNT_W'(1);
					end
				end
				OP_EMIT: begin
					digs_q <= {digs_q[VALUE_W-5:0], 4'h0};
					cnt_q  <= cnt_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
		if (emit) begin
			if (ctrl.op == OP_MINUS) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= digit_char(digs_q[VALUE_W-1 -: 4], upper_q);
				last_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				total_q     <= total_inc;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.in_hex    = in_hex;
	assign stat.neg       = neg_q;
	assign stat.cnt_one   = (cnt_q == CNT_W'(1));
	assign stat.skip_more = skip_more;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;
	assign out_total = total_q;

endmodule
`default_nettype wire
